/* src/sort_pkg.sv */
// Shared types and constants for the scene object revision tracker.
// No dependencies.
`timescale 1ns / 1ps
package sort_pkg;
  localparam int Entries = 256;
  localparam int IdxW = 8;
  localparam int CntW = 9;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_TOUCH = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_WAIT, S_TOUCH_RD, S_TOUCH_WR,
    S_SWP_RD, S_SWP_WR, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic do_begin;
    logic scan_clr;
    logic scan_step;
    logic rd_issue;
    logic touch_wr;
    logic swp_wr;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       id_zero;
    logic       scan_last;
    logic       scan_hit;
    logic       have_slot;
  } stat_t;
endpackage

/* src/scene_object_revision_tracker_core.sv */
// Top level of the scene object revision tracker: controller plus datapath.
// Depends on sort_pkg, sort_ctrl, sort_datapath.
`timescale 1ns / 1ps
// Tracks up to 256 scene objects by id with their revisions. One word in,
// one word out. Begin frame, a touch with id zero and unused opcodes skip the
// table; a touch walks the whole id memory one slot a cycle, and the end of
// frame sweep does a read and a write per slot, as the table memory port
// allows. A new word is taken only once the previous result is taken or
// being taken. Statistics come with every result.
module scene_object_revision_tracker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [63:0] frame_number,
  input  logic [63:0] object_id,
  input  logic [31:0] topology_rev,
  input  logic [31:0] deformation_rev,
  input  logic [31:0] transform_rev,
  input  logic [31:0] material_rev,
  input  logic        allow_refit,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        build_structure,
  output logic        refit_structure,
  output logic        update_top_level,
  output logic        update_material,
  output logic        table_full,
  output logic [15:0] built_count,
  output logic [15:0] refit_count,
  output logic [15:0] reused_count,
  output logic [15:0] top_level_count,
  output logic [15:0] material_count,
  output logic [8:0]  pending_count,
  output logic [8:0]  retired_count
);
  sort_pkg::cmd_t  cmd;
  sort_pkg::stat_t st;

  sort_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .cmd, .st
  );

  sort_datapath u_dp (
    .clk, .rst, .cmd, .st, .cfg_we, .cfg_wdata,
    .opcode, .frame_number, .object_id, .topology_rev, .deformation_rev,
    .transform_rev, .material_rev, .allow_refit,
    .build_structure, .refit_structure, .update_top_level, .update_material,
    .table_full, .built_count, .refit_count, .reused_count, .top_level_count,
    .material_count, .pending_count, .retired_count
  );
endmodule

/* src/sort_datapath.sv */
// Slot table, scan logic, revision compare and statistics counters.
// Depends on sort_pkg.
`timescale 1ns / 1ps
module sort_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  sort_pkg::cmd_t       cmd,
  output sort_pkg::stat_t      st,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic [1:0]           opcode,
  input  logic [63:0]          frame_number,
  input  logic [63:0]          object_id,
  input  logic [31:0]          topology_rev,
  input  logic [31:0]          deformation_rev,
  input  logic [31:0]          transform_rev,
  input  logic [31:0]          material_rev,
  input  logic                 allow_refit,
  output logic                 build_structure,
  output logic                 refit_structure,
  output logic                 update_top_level,
  output logic                 update_material,
  output logic                 table_full,
  output logic [15:0]          built_count,
  output logic [15:0]          refit_count,
  output logic [15:0]          reused_count,
  output logic [15:0]          top_level_count,
  output logic [15:0]          material_count,
  output logic [8:0]           pending_count,
  output logic [8:0]           retired_count
);
  // latched input word
  logic [1:0]  op;
  logic [63:0] frm;
  logic [63:0] id;
  logic [31:0] top, def, tra, mat;
  logic        refit_ok;

  // configuration and frame
  logic [7:0]  fif;
  logic [63:0] cur_frame;

  // table: valid bits in flops, payload in memories
  logic [sort_pkg::Entries-1:0] valid;
  logic [63:0] mem_obj [sort_pkg::Entries];
  logic [127:0] mem_rev [sort_pkg::Entries];
  logic [63:0] mem_seen [sort_pkg::Entries];
  logic [64:0] mem_ret [sort_pkg::Entries]; // {pending, retire frame}

  // scan pointer and results
  logic [sort_pkg::CntW-1:0] ptr;
  logic [sort_pkg::IdxW-1:0] idx, hit_idx, free_idx;
  logic hit_found, free_found;
  logic [63:0] rd_obj;
  logic [127:0] rd_rev;
  logic [63:0] rd_seen;
  logic [64:0] rd_ret;
  logic rd_valid;

  // counters
  logic [15:0] c_built, c_refit, c_reused, c_top, c_mat;
  logic [8:0]  c_pend, c_ret;

  assign idx = ptr[sort_pkg::IdxW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op <= opcode; frm <= frame_number; id <= object_id; top <= topology_rev;
      def <= deformation_rev; tra <= transform_rev; mat <= material_rev;
      refit_ok <= allow_refit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) fif <= 8'd1;
    else if (cfg_we) fif <= cfg_wdata;
  end

  // object id memory read for the scan, one slot a cycle
  always_ff @(posedge clk) begin
    rd_obj <= mem_obj[idx];
    rd_valid <= valid[idx];
  end

  // scan bookkeeping; the compare works on the slot the pointer named in the previous cycle
  logic [sort_pkg::IdxW-1:0] cmp_idx;
  logic cmp_live;
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clr) begin
      ptr <= '0; hit_found <= 1'b0; free_found <= 1'b0; cmp_live <= 1'b0;
      cmp_idx <= '0;
    end else if (cmd.scan_step) begin
      if (!ptr[sort_pkg::IdxW]) ptr <= ptr + 1'b1;
      cmp_live <= !ptr[sort_pkg::IdxW];
      cmp_idx <= idx;
      if (cmp_live) begin
        if (rd_valid && !hit_found && rd_obj == id) begin
          hit_found <= 1'b1; hit_idx <= cmp_idx;
        end
        if (!rd_valid && !free_found) begin
          free_found <= 1'b1; free_idx <= cmp_idx;
        end
      end
    end
  end

  assign st.op = op;
  assign st.id_zero = (id == 64'd0);
  assign st.scan_last = ptr[sort_pkg::IdxW] && !cmp_live;
  assign st.scan_hit = hit_found;
  assign st.have_slot = hit_found || free_found;

  // slot under work: scan result for touch, pointer for sweep
  logic [sort_pkg::IdxW-1:0] wk;
  assign wk = (op == sort_pkg::OP_TOUCH) ? (hit_found ? hit_idx : free_idx) : idx;

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_rev <= mem_rev[wk]; rd_seen <= mem_seen[wk]; rd_ret <= mem_ret[wk];
    end
  end

  // touch decision
  logic f_build, f_refit, f_top, f_mat;
  always_comb begin
    f_build = 1'b0; f_refit = 1'b0; f_top = 1'b0; f_mat = 1'b0;
    if (!hit_found) begin
      f_build = 1'b1; f_top = 1'b1; f_mat = 1'b1;
    end else begin
      if (rd_rev[127:96] != top) begin
        f_build = 1'b1; f_top = 1'b1;
      end else if (rd_rev[95:64] != def) begin
        if (refit_ok) f_refit = 1'b1;
        else f_build = 1'b1;
      end
      if (rd_rev[63:32] != tra) f_top = 1'b1;
      if (rd_rev[31:0] != mat) f_mat = 1'b1;
    end
  end

  // sweep decision
  logic [63:0] delay, ret_new, ret_use;
  logic [64:0] sum;
  logic s_act, s_free;
  assign delay = {56'd0, (fif == 8'd0) ? 8'd1 : fif};
  assign sum = {1'b0, cur_frame} + {1'b0, delay};
  assign ret_new = sum[64] ? {64{1'b1}} : sum[63:0];
  assign ret_use = rd_ret[64] ? rd_ret[63:0] : ret_new;
  assign s_act = valid[wk] && (rd_seen != cur_frame);
  assign s_free = cur_frame >= ret_use;

  // table writes
  always_ff @(posedge clk) begin
    if (cmd.touch_wr) begin
      mem_obj[wk] <= id;
      mem_rev[wk] <= {top, def, tra, mat};
      mem_seen[wk] <= cur_frame;
      mem_ret[wk] <= 65'd0;
    end else if (cmd.swp_wr && s_act) begin
      mem_ret[wk] <= {1'b1, ret_use};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else if (cmd.touch_wr) valid[wk] <= 1'b1;
    else if (cmd.swp_wr && s_act && s_free) valid[wk] <= 1'b0;
  end

  // frame and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_frame <= '0;
      c_built <= '0; c_refit <= '0; c_reused <= '0; c_top <= '0; c_mat <= '0;
      c_pend <= '0; c_ret <= '0;
    end else if (cmd.do_begin) begin
      cur_frame <= frm;
      c_built <= '0; c_refit <= '0; c_reused <= '0; c_top <= '0; c_mat <= '0;
      c_pend <= '0; c_ret <= '0;
    end else if (cmd.touch_wr) begin
      if (f_build) c_built <= c_built + {15'd0, c_built != 16'hFFFF};
      else if (f_refit) c_refit <= c_refit + {15'd0, c_refit != 16'hFFFF};
      else c_reused <= c_reused + {15'd0, c_reused != 16'hFFFF};
      if (f_top) c_top <= c_top + {15'd0, c_top != 16'hFFFF};
      if (f_mat) c_mat <= c_mat + {15'd0, c_mat != 16'hFFFF};
    end else if (cmd.swp_wr && s_act) begin
      if (s_free) c_ret <= c_ret + {8'd0, c_ret != 9'h1FF};
      else c_pend <= c_pend + {8'd0, c_pend != 9'h1FF};
    end
  end

  // output word register
  logic touch_ok, full_flag;
  assign touch_ok = (op == sort_pkg::OP_TOUCH) && !st.id_zero && st.have_slot;
  assign full_flag = (op == sort_pkg::OP_TOUCH) && !st.id_zero && !st.have_slot;
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      build_structure <= touch_ok && f_build;
      refit_structure <= touch_ok && f_refit;
      update_top_level <= touch_ok && f_top;
      update_material <= touch_ok && f_mat;
      table_full <= full_flag;
      built_count <= c_built; refit_count <= c_refit; reused_count <= c_reused;
      top_level_count <= c_top; material_count <= c_mat;
      pending_count <= c_pend; retired_count <= c_ret;
    end
  end
endmodule

/* src/sort_ctrl.sv */
// Sequencer for begin, touch and sweep operations.
// Depends on sort_pkg.
`timescale 1ns / 1ps
module sort_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output sort_pkg::cmd_t  cmd,
  input  sort_pkg::stat_t st
);
  sort_pkg::state_t state, state_next;
  logic [sort_pkg::IdxW:0] cnt;
  logic ov;

  always_ff @(posedge clk) begin
    if (rst) state <= sort_pkg::S_IDLE;
    else state <= state_next;
  end

  // sweep slot counter
  always_ff @(posedge clk) begin
    if (rst || state == sort_pkg::S_IDLE) cnt <= '0;
    else if (state == sort_pkg::S_SWP_WR) cnt <= cnt + 1'b1;
  end

  // output valid register, held until taken
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (state == sort_pkg::S_OUT) ov <= 1'b1;
    else if (out_ready) ov <= 1'b0;
  end
  assign out_valid = ov;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sort_pkg::S_IDLE: if (in_valid && in_ready) state_next = sort_pkg::S_SCAN;
      sort_pkg::S_SCAN: begin
        case (st.op)
          sort_pkg::OP_TOUCH: state_next = st.id_zero ? sort_pkg::S_OUT
                                                      : sort_pkg::S_SCAN_WAIT;
          sort_pkg::OP_SWEEP: state_next = sort_pkg::S_SWP_RD;
          default:            state_next = sort_pkg::S_OUT;
        endcase
      end
      sort_pkg::S_SCAN_WAIT: if (st.scan_last)
        state_next = st.have_slot ? sort_pkg::S_TOUCH_RD : sort_pkg::S_OUT;
      sort_pkg::S_TOUCH_RD: state_next = sort_pkg::S_TOUCH_WR;
      sort_pkg::S_TOUCH_WR: state_next = sort_pkg::S_OUT;
      sort_pkg::S_SWP_RD:   state_next = sort_pkg::S_SWP_WR;
      sort_pkg::S_SWP_WR:   state_next = cnt[sort_pkg::IdxW-1:0] == '1 ?
                                         sort_pkg::S_OUT : sort_pkg::S_SWP_RD;
      sort_pkg::S_OUT:      state_next = sort_pkg::S_IDLE;
      default:              state_next = sort_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = (state == sort_pkg::S_IDLE) && (!ov || out_ready);
    case (state)
      sort_pkg::S_IDLE: begin
        cmd.load_in = in_valid && in_ready;
        cmd.scan_clr = 1'b1;
      end
      // begin frame takes the latched frame number
      sort_pkg::S_SCAN:      cmd.do_begin = (st.op == sort_pkg::OP_BEGIN);
      sort_pkg::S_SCAN_WAIT: cmd.scan_step = 1'b1;
      sort_pkg::S_TOUCH_RD:  cmd.rd_issue = 1'b1;
      sort_pkg::S_TOUCH_WR:  cmd.touch_wr = 1'b1;
      sort_pkg::S_SWP_RD:    cmd.rd_issue = 1'b1;
      // the slot pointer advances after each sweep write
      sort_pkg::S_SWP_WR: begin
        cmd.swp_wr = 1'b1; cmd.scan_step = 1'b1;
      end
      sort_pkg::S_OUT:       cmd.out_load = 1'b1;
      default: ;
    endcase
  end
endmodule
